### rtl/sipc_pkg.sv
// sipc_pkg: shared types, header-name table and character helpers for the
// header name classifier; used by sipc_in_reg, sipc_match and the top level
`default_nettype none

package sipc_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int ENTRY_COUNT = 73;
    localparam int TEXT_BYTES  = 20;
    localparam int LEN_W       = 5;
    localparam int TYPE_W      = 6;
    localparam int OUT_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NAME_ONLY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA     = 1'd1;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [ENTRY_COUNT-1:0] mask_t;
    typedef logic [TYPE_W-1:0]      hdr_type_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    typedef struct packed {
        mask_t     alive_next;
        hdr_type_t type_after;
        hdr_type_t type_before;
    } match_t;

    // lower-case names, right-aligned, first character in the highest used byte
    localparam logic [8*TEXT_BYTES-1:0] ENTRY_TEXT [ENTRY_COUNT] = '{
        "a", "accept", "accept-contact", "accept-language",
        "allow", "allow-events", "authorization",
        "b",
        "c", "call-id", "call-info", "contact",
        "content-disposition", "content-encoding",
        "content-length", "content-type", "cseq",
        "d", "date", "diversion",
        "e", "event", "expires",
        "f", "from",
        "i", "identity", "identity-info",
        "j", "k", "l",
        "m", "max-forwards", "min-expires", "min-se",
        "o", "organization",
        "path", "priority", "privacy", "proxy-authenticate",
        "proxy-authorization", "proxy-require",
        "p-preferred-identity", "p-asserted-identity",
        "r", "reason", "record-route", "refer-to",
        "referred-by", "reject-contact", "remote-party-id",
        "request-disposition", "require", "retry-after",
        "route",
        "s", "server", "session-expires", "sip-if-match",
        "subject", "subscription-state", "supported",
        "t", "to",
        "u", "unsupported", "user-agent",
        "v", "via",
        "x", "y",
        "www-authenticate"
    };

    localparam logic [LEN_W-1:0] ENTRY_LEN [ENTRY_COUNT] = '{
        5'd1, 5'd6, 5'd14, 5'd15, 5'd5, 5'd12, 5'd13,
        5'd1,
        5'd1, 5'd7, 5'd9, 5'd7, 5'd19, 5'd16, 5'd14, 5'd12, 5'd4,
        5'd1, 5'd4, 5'd9,
        5'd1, 5'd5, 5'd7,
        5'd1, 5'd4,
        5'd1, 5'd8, 5'd13,
        5'd1, 5'd1, 5'd1,
        5'd1, 5'd12, 5'd11, 5'd6,
        5'd1, 5'd12,
        5'd4, 5'd8, 5'd7, 5'd18, 5'd19, 5'd13, 5'd20, 5'd19,
        5'd1, 5'd6, 5'd12, 5'd8, 5'd11, 5'd14, 5'd15, 5'd19, 5'd7, 5'd11,
        5'd5,
        5'd1, 5'd6, 5'd15, 5'd12, 5'd7, 5'd18, 5'd9,
        5'd1, 5'd2,
        5'd1, 5'd11, 5'd10,
        5'd1, 5'd3,
        5'd1, 5'd1,
        5'd16
    };

    localparam logic [TYPE_W-1:0] ENTRY_CODE [ENTRY_COUNT] = '{
        6'd1, 6'd2, 6'd1, 6'd3, 6'd4, 6'd5, 6'd6,
        6'd7,
        6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd8, 6'd15,
        6'd16, 6'd17, 6'd18,
        6'd13, 6'd19, 6'd20,
        6'd21, 6'd21,
        6'd9, 6'd22, 6'd23,
        6'd24, 6'd25, 6'd14,
        6'd11, 6'd26, 6'd27, 6'd28,
        6'd19, 6'd29,
        6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37,
        6'd38, 6'd39, 6'd40, 6'd38, 6'd7, 6'd24, 6'd41, 6'd16, 6'd42, 6'd43,
        6'd44,
        6'd45, 6'd46, 6'd47, 6'd48, 6'd45, 6'd49, 6'd25,
        6'd50, 6'd50,
        6'd5, 6'd51, 6'd52,
        6'd53, 6'd53,
        6'd47, 6'd22,
        6'd54
    };

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] entry_char(input int e, input logic [LEN_W-1:0] p);
        int idx;
        idx = int'(ENTRY_LEN[e]) - 1 - int'(p);
        if (idx < 0)
        begin
            return 8'd0;
        end
        return ENTRY_TEXT[e][8*idx +: 8];
    endfunction

    function automatic logic is_name_char(input logic [7:0] b, input logic [31:0] extra);
        logic hit;
        hit = (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z")
            || b == "-" || b == "." || b == "_" || b == "+" || b == "~";
        for (int i = 0; i < 4; i++)
        begin
            if (extra[8*i +: 8] != 8'd0 && extra[8*i +: 8] == b)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic count_t sat_inc(input count_t x);
        return (x == '1) ? x : x + count_t'(1);
    endfunction

endpackage

`default_nettype wire

### rtl/sipc_in_reg.sv
// sipc_in_reg: input register stage holding one beat for the classify stage
// depends on sipc_pkg
`default_nettype none

module sipc_in_reg
    import sipc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire beat_t in_beat,
    input  wire logic  take,
    output logic       beat_valid,
    output beat_t      beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= in_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

### rtl/sipc_match.sv
// sipc_match: candidate mask narrowing against the header-name table and
// type lookup for the current byte; depends on sipc_pkg
`default_nettype none

module sipc_match
    import sipc_pkg::*;
(
    input  wire mask_t      mask_base,
    input  wire logic [7:0] data,
    input  wire count_t     pos,
    output match_t          result
);

    localparam int CW1 = COUNT_BITS + 1;

    logic [7:0] folded;
    logic       hit;

    assign folded = fold_case(data);

    always_comb
    begin
        result = '0;
        hit    = 1'b0;
        for (int e = 0; e < ENTRY_COUNT; e++)
        begin
            hit = (pos < COUNT_BITS'(ENTRY_LEN[e]))
                && (folded == entry_char(e, pos[LEN_W-1:0]));
            result.alive_next[e] = mask_base[e] && hit;
            if (result.alive_next[e] && CW1'(ENTRY_LEN[e]) == CW1'(pos) + CW1'(1))
            begin
                result.type_after = result.type_after | ENTRY_CODE[e];
            end
            if (mask_base[e] && COUNT_BITS'(ENTRY_LEN[e]) == pos)
            begin
                result.type_before = result.type_before | ENTRY_CODE[e];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/sip_header_name_classifier.sv
// sip_header_name_classifier: top level, parse control, configuration and result register
// depends on sipc_pkg, sipc_in_reg and sipc_match
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   data_byte, last_byte
//   out      output     out_valid / out_ready status, header_type, name_length, consumed
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one byte per cycle while no held result stalls the input register; the result register loads
// after the byte is accepted into the input register, then the table match and parse step
// at most one result per buffer, given on the byte that decides it
// reset empties both registers and returns the parser to the first-byte state
// a held result stalls the input register; the input side still takes a beat
// in the cycle the held result leaves
`default_nettype none

module sip_header_name_classifier
    import sipc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 last_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      status,
    output logic [TYPE_W-1:0]         header_type,
    output logic [OUT_W-1:0]          name_length,
    output logic [OUT_W-1:0]          consumed,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam logic [1:0] PH_WAIT  = 2'd0;
    localparam logic [1:0] PH_NAME  = 2'd1;
    localparam logic [1:0] PH_COLON = 2'd2;
    localparam logic [1:0] PH_SKIP  = 2'd3;

    logic        name_only_reg;
    logic [31:0] extra_reg;

    logic   [1:0] phase_reg;
    logic   [1:0] phase_next;
    mask_t        alive_reg;
    mask_t        alive_next;
    count_t       cnt_reg;
    count_t       cnt_next;
    count_t       pos_reg;
    count_t       pos_next;

    logic                out_valid_reg;
    logic                status_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [OUT_W-1:0]    len_reg;
    logic [OUT_W-1:0]    cons_reg;

    beat_t  in_beat;
    beat_t  beat;
    logic   beat_valid;
    logic   adv;
    match_t m;

    mask_t     base_mask;
    count_t    base_cnt;
    count_t    base_pos;
    logic      is_name;
    logic      colon_ok;
    logic      ws_hold;
    logic      emit;
    logic      err;
    logic      done;
    hdr_type_t type_res;
    count_t    len_res;
    count_t    cons_res;

    assign in_beat.data = data_byte;
    assign in_beat.last = last_byte;
    assign adv          = beat_valid && (!out_valid_reg || out_ready);

    sipc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_beat    (in_beat),
        .take       (adv),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    assign base_mask = (phase_reg == PH_WAIT) ? '1 : alive_reg;
    assign base_cnt  = (phase_reg == PH_WAIT) ? '0 : cnt_reg;
    assign base_pos  = (phase_reg == PH_WAIT) ? '0 : pos_reg;

    sipc_match u_match (
        .mask_base (base_mask),
        .data      (beat.data),
        .pos       (base_cnt),
        .result    (m)
    );

    assign is_name  = is_name_char(beat.data, extra_reg);
    assign colon_ok = (beat.data == CH_COLON);
    assign ws_hold  = (beat.data == CH_SPACE || beat.data == CH_TAB) && !beat.last;

    always_comb
    begin
        phase_next = phase_reg;
        alive_next = alive_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        emit       = 1'b0;
        err        = 1'b0;
        done       = 1'b0;
        type_res   = '0;
        len_res    = cnt_reg;
        cons_res   = '0;
        if (adv)
        begin
            unique case (phase_reg)
                PH_WAIT, PH_NAME:
                begin
                    alive_next = base_mask;
                    cnt_next   = base_cnt;
                    pos_next   = base_pos;
                    if (!is_name && phase_reg == PH_WAIT)
                    begin
                        emit = 1'b1;
                        err  = 1'b1;
                        done = 1'b1;
                    end
                    else if (is_name)
                    begin
                        alive_next = m.alive_next;
                        cnt_next   = sat_inc(base_cnt);
                        pos_next   = sat_inc(base_pos);
                        phase_next = PH_NAME;
                        if (beat.last)
                        begin
                            done = 1'b1;
                            emit = 1'b1;
                            if (name_only_reg)
                            begin
                                type_res = m.type_after;
                                len_res  = cnt_next;
                                cons_res = cnt_next;
                            end
                            else
                            begin
                                err = 1'b1;
                            end
                        end
                    end
                    else if (name_only_reg)
                    begin
                        done     = 1'b1;
                        emit     = 1'b1;
                        type_res = m.type_before;
                        cons_res = cnt_reg;
                    end
                    else if (colon_ok)
                    begin
                        done     = 1'b1;
                        emit     = 1'b1;
                        type_res = m.type_before;
                        cons_res = sat_inc(pos_reg);
                    end
                    else if (ws_hold)
                    begin
                        pos_next   = sat_inc(pos_reg);
                        phase_next = PH_COLON;
                    end
                    else
                    begin
                        done = 1'b1;
                        emit = 1'b1;
                        err  = 1'b1;
                    end
                end
                PH_COLON:
                begin
                    if (colon_ok)
                    begin
                        done     = 1'b1;
                        emit     = 1'b1;
                        type_res = m.type_before;
                        cons_res = sat_inc(pos_reg);
                    end
                    else if (ws_hold)
                    begin
                        pos_next = sat_inc(pos_reg);
                    end
                    else
                    begin
                        done = 1'b1;
                        emit = 1'b1;
                        err  = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                end
            endcase
            if (beat.last)
            begin
                phase_next = PH_WAIT;
            end
            else if (done)
            begin
                phase_next = PH_SKIP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            alive_reg     <= '1;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            name_only_reg <= 1'b0;
            extra_reg     <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            alive_reg <= alive_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            if (adv)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NAME_ONLY)
                begin
                    name_only_reg <= cfg_data[0];
                end
                else if (cfg_index == REG_EXTRA)
                begin
                    extra_reg <= cfg_data;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            status_reg <= err;
            type_reg   <= err ? '0 : type_res;
            len_reg    <= err ? '0 : OUT_W'(len_res);
            cons_reg   <= err ? '0 : OUT_W'(cons_res);
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign header_type = type_reg;
    assign name_length = len_reg;
    assign consumed    = cons_reg;

    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        adv && phase_reg == PH_SKIP |=> !out_valid_reg)
        else $error("result produced while skipping to end of buffer");

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        adv && beat.last |=> phase_reg == PH_WAIT)
        else $error("parser not back at first byte after last beat");

    a_colon_has_name: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_COLON |-> cnt_reg != '0 && pos_reg >= cnt_reg)
        else $error("waiting for colon without a name");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        adv && emit && err |=> out_valid_reg && status_reg
            && type_reg == '0 && len_reg == '0 && cons_reg == '0)
        else $error("error result carries nonzero fields");

endmodule

`default_nettype wire
